/* rtl/core/event_camera_noise_filter_top_assert.svh */
// Assertion macros for the event camera noise filter.
// Included by the top level; needs clk and rst in scope.
`ifndef EVENT_CAMERA_NOISE_FILTER_TOP_ASSERT_SVH
`define EVENT_CAMERA_NOISE_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ecnf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the event camera noise filter.
// No dependencies; used by the controller, the datapath and the top level.
package ecnf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_RING_DEPTH = 12;
  localparam int DEF_TIME_BITS  = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLICKER_WIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_H     = 3'd4;

  localparam logic [23:0] RST_MAX_INTERVAL = 24'd10000;
  localparam logic [2:0]  RST_RADIUS       = 3'd1;
  localparam logic [23:0] RST_FLICKER_WIN  = 24'd100000;
  localparam logic [8:0]  RST_SENSOR_W     = 9'd256;
  localparam logic [8:0]  RST_SENSOR_H     = 9'd256;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD,
    S_UPD,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic calc;
    logic rd_pix;
    logic update;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic win_empty;
  } sts_t;

endpackage

/* rtl/core/ecnf_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the event camera noise filter: sequences clear, lookup,
// update, neighbor scan and result hand-off. Depends on ecnf_pkg.
module ecnf_ctrl import ecnf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic m_tready,
  output logic m_tvalid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = sts.win_empty ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // The result register stays full until the consumer takes it.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  assign m_tvalid = out_valid;

endmodule

/* rtl/core/ecnf_dp.sv */
`timescale 1ns / 1ps
// Datapath of the event camera noise filter: configuration registers, pixel
// time stores, polarity-change rings and the neighbor scan. Depends on ecnf_pkg.
module ecnf_dp import ecnf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [7:0]            in_x,
  input  logic [7:0]            in_y,
  input  logic                  in_pol,
  input  logic [47:0]           in_ts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]            out_data
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int CW   = XW + 4;
  localparam int RW   = YW + 4;
  localparam int PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MW   = PW + 2;

  // Configuration registers.
  logic [23:0] max_int;
  logic [2:0]  radius;
  logic [23:0] flk_win;
  logic [8:0]  sens_w;
  logic [8:0]  sens_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_int <= RST_MAX_INTERVAL;
      radius  <= RST_RADIUS;
      flk_win <= RST_FLICKER_WIN;
      sens_w  <= RST_SENSOR_W;
      sens_h  <= RST_SENSOR_H;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_INTERVAL: max_int <= cfg_data[23:0];
        CFG_RADIUS:       radius  <= cfg_data[2:0];
        CFG_FLICKER_WIN:  flk_win <= cfg_data[23:0];
        CFG_SENSOR_W:     sens_w  <= cfg_data[8:0];
        CFG_SENSOR_H:     sens_h  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Coordinate wrap into the store, as constant lookup tables over the 8-bit input.
  logic [XW-1:0] wrap_x [256];
  logic [YW-1:0] wrap_y [256];
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_x[g] = XW'(g % MAX_WIDTH);
    assign wrap_y[g] = YW'(g % MAX_HEIGHT);
  end

  logic [63:0] ts_ext;
  assign ts_ext = 64'(in_ts);

  // Captured event.
  logic [XW-1:0]        x_q;
  logic [YW-1:0]        y_q;
  logic                 pol_q;
  logic [TIME_BITS-1:0] ts_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_q   <= wrap_x[in_x];
      y_q   <= wrap_y[in_y];
      pol_q <= in_pol;
      ts_q  <= ts_ext[TIME_BITS-1:0];
    end
  end

  // Address, window bounds and time thresholds.
  logic [TIME_BITS-1:0] mi_ext, fw_ext;
  logic [10:0]          w_cl, h_cl;
  logic [CW-1:0]        xe, rxe, wm1, c0_c, c1_c;
  logic [RW-1:0]        ye, rye, hm1, r0_c, r1_c;

  assign mi_ext = TIME_BITS'(max_int);
  assign fw_ext = TIME_BITS'(flk_win);

  always_comb begin
    w_cl = (sens_w == 9'd0) ? 11'd1 :
           (11'(sens_w) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(sens_w);
    h_cl = (sens_h == 9'd0) ? 11'd1 :
           (11'(sens_h) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : 11'(sens_h);
    wm1  = CW'(w_cl - 11'd1);
    hm1  = RW'(h_cl - 11'd1);
    xe   = CW'(x_q);
    ye   = RW'(y_q);
    rxe  = CW'(radius);
    rye  = RW'(radius);
    c0_c = (xe >= rxe) ? xe - rxe : '0;
    r0_c = (ye >= rye) ? ye - rye : '0;
    c1_c = (xe + rxe > wm1) ? wm1 : xe + rxe;
    r1_c = (ye + rye > hm1) ? hm1 : ye + rye;
  end

  logic [AW-1:0]        idx;
  logic [CW-1:0]        c0, c1, cur_c;
  logic [RW-1:0]        r0, r1, cur_r;
  logic                 win_empty;
  logic [TIME_BITS-1:0] th_s, th_f;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      idx       <= AW'(AW'(y_q) * AW'(MAX_WIDTH)) + AW'(x_q);
      c0        <= c0_c;
      c1        <= c1_c;
      r0        <= r0_c;
      r1        <= r1_c;
      win_empty <= (c0_c > c1_c) || (r0_c > r1_c);
      th_s      <= (ts_q > mi_ext) ? ts_q - mi_ext : '0;
      th_f      <= (ts_q > fw_ext) ? ts_q - fw_ext : '0;
    end
  end

  // Stores; cleared by a pass over all pixels after reset.
  logic [TIME_BITS-1:0] pos_mem [NPIX];
  logic [TIME_BITS-1:0] neg_mem [NPIX];
  logic [RING_DEPTH-1:0][TIME_BITS-1:0] ring_mem [NPIX];
  logic [MW-1:0]        meta_mem [NPIX];

  logic [AW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + AW'(1);
  end

  logic [AW-1:0] scan_addr, rd_addr;
  assign scan_addr = AW'(AW'(cur_r[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(cur_c[XW-1:0]);
  assign rd_addr   = cmd.rd_pix ? idx : scan_addr;

  logic [TIME_BITS-1:0] pos_q, neg_q;
  logic [RING_DEPTH-1:0][TIME_BITS-1:0] ring_q;
  logic [MW-1:0]        meta_q;

  // Update of the event's own pixel.
  logic [TIME_BITS-1:0] own_t, oth_t, old_slot;
  logic                 red, chg, flk;
  logic [PW-1:0]        ptr, ptr2;
  logic [RING_DEPTH-1:0][TIME_BITS-1:0] new_row;

  always_comb begin
    own_t   = pol_q ? pos_q : neg_q;
    oth_t   = pol_q ? neg_q : pos_q;
    red     = (own_t > oth_t) && (own_t != '0) &&
              !((ts_q > own_t) && ((ts_q - own_t) > mi_ext));
    ptr     = meta_q[PW-1:0];
    chg     = !meta_q[MW-1] || (meta_q[MW-2] != pol_q);
    new_row = ring_q;
    ptr2    = ptr;
    if (chg) begin
      new_row[ptr] = ts_q;
      ptr2 = (ptr == PW'(RING_DEPTH - 1)) ? '0 : ptr + PW'(1);
    end
    old_slot = new_row[ptr2];
    flk      = old_slot > th_f;
  end

  logic pos_we, neg_we, ring_we;
  logic [AW-1:0] wr_addr;
  assign wr_addr = cmd.clear ? clr_addr : idx;
  assign pos_we  = cmd.clear || (cmd.update && !red && pol_q);
  assign neg_we  = cmd.clear || (cmd.update && !red && !pol_q);
  assign ring_we = cmd.clear || (cmd.update && chg);

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= cmd.clear ? '0 : ts_q;
    pos_q <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (neg_we) neg_mem[wr_addr] <= cmd.clear ? '0 : ts_q;
    neg_q <= neg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wr_addr] <= cmd.clear ? '0 : new_row;
    ring_q <= ring_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (ring_we) meta_mem[wr_addr] <= cmd.clear ? '0 : {1'b1, pol_q, ptr2};
    meta_q <= meta_mem[idx];
  end

  // Neighbor scan: address issued one cycle, data compared the next.
  logic red_q, flk_q, sup_q, cmp_v;
  logic [TIME_BITS-1:0] nb_t;
  assign nb_t = pol_q ? pos_q : neg_q;

  always_ff @(posedge clk) begin
    if (rst) cmp_v <= 1'b0;
    else     cmp_v <= cmd.scan_step;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      red_q <= red;
      flk_q <= flk;
      sup_q <= 1'b0;
      cur_c <= c0;
      cur_r <= r0;
    end else begin
      if (cmd.scan_step) begin
        if (cur_r == r1) begin
          cur_r <= r0;
          cur_c <= cur_c + CW'(1);
        end else begin
          cur_r <= cur_r + RW'(1);
        end
      end
      if (cmp_v && (nb_t > th_s) && (nb_t < ts_q)) sup_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= {4'b0, flk_q, sup_q, red_q, !red_q && sup_q && !flk_q};
  end

  assign sts.clear_last = (clr_addr == AW'(NPIX - 1));
  assign sts.scan_last  = (cur_c == c1) && (cur_r == r1);
  assign sts.win_empty  = win_empty;

endmodule

/* rtl/core/event_camera_noise_filter_top.sv */
`timescale 1ns / 1ps
// Sequence per event: address, store read and update states, then a scan of every pixel of
// the clipped neighbor window (9 pixels at radius 1 away from the edges) and a tail state,
// unless the window is empty. One event at a time; a result still waiting holds off the next one.
// The scan is bounded by the single read port of each time store, which it walks one
// pixel per cycle.
// Reset: synchronous; a clearing pass over all MAX_WIDTH * MAX_HEIGHT pixels zeroes all stores.
module event_camera_noise_filter_top import ecnf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [71:0]           s_axis_tdata,   // pix_x, pix_y, polarity, timestamp_us
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // keep, redundant flag, has_support, flicker flag
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ecnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tready (m_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  ecnf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RING_DEPTH (RING_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (s_axis_tdata[7:0]),
    .in_y      (s_axis_tdata[15:8]),
    .in_pol    (s_axis_tdata[16]),
    .in_ts     (s_axis_tdata[64:17]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

`include "event_camera_noise_filter_top_assert.svh"

  `ECNF_ASSERT_NEXT(a_one_event, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken during processing")
  `ECNF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_axis_tvalid || m_axis_tready, "result overwritten before taken")
  `ECNF_ASSERT_NEXT(a_load_shows, cmd.load_out, m_axis_tvalid, "loaded result not presented")
  `ECNF_ASSERT_NOW(a_no_accept_clear, cmd.clear, !s_axis_tready, "request taken during clearing pass")

endmodule
